// ===== design/fss_pkg.sv =====
// Package of the fuzzy subsequence scorer: sizes, operation codes, structs and case folding.
package fss_pkg;

   localparam int QUERY_DEPTH = 64;
   localparam int ADDR_W      = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
   localparam int LEN_W       = $clog2(QUERY_DEPTH + 1);
   localparam int BONUS_W     = $clog2(QUERY_DEPTH + 2);

   localparam int GLYPH_W    = 21;
   localparam int OP_W       = 3;
   localparam int PRIORITY_W = 14;
   localparam int SCORE_W    = 15;

   localparam logic [SCORE_W-1:0] BASE_SCORE = SCORE_W'(10000);
   localparam logic [SCORE_W-1:0] SCORE_MAX  = SCORE_W'(32767);

   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_TEXT   = 3'd3;
   localparam logic [OP_W-1:0] OP_EMPTY  = 3'd4;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [GLYPH_W-1:0] data;
   } mem_write_type;

   typedef struct packed {
      logic               valid;
      logic [SCORE_W-1:0] score;
      logic               matched;
   } result_type;

   // ASCII and Latin-1 capitals fold to lower case; everything else is unchanged.
   function automatic logic [GLYPH_W-1:0] fold_case(input logic [GLYPH_W-1:0] g);
      logic [GLYPH_W-1:0] f;
      f = g;
      if ((g >= 21'h41 && g <= 21'h5A) || (g >= 21'hC0 && g <= 21'hDE && g != 21'hD7)) begin
         f = g + 21'h20;
      end
      return f;
   endfunction

endpackage

// ===== design/fss_query_mem.sv =====
// Query glyph store: synchronous memory with a registered read and write-to-read forwarding.
module fss_query_mem
   import fss_pkg::*;
(
   input  logic               clock,
   input  mem_write_type      wr,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [GLYPH_W-1:0] rd_data
);

   logic [GLYPH_W-1:0] store_ff [QUERY_DEPTH];
   logic [GLYPH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr] <= wr.data;
      end
   end

   // A write to the address being read hands its data straight to the read register.
   always_ff @(posedge clock) begin
      if (wr.en && wr.addr == rd_addr) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fss_match_engine.sv =====
// Query bookkeeping and greedy subsequence scoring, one transaction per cycle in which one is accepted.
module fss_match_engine
   import fss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [OP_W-1:0]       operation,
   input  logic [GLYPH_W-1:0]    glyph,
   input  logic                  last_glyph,
   input  logic [PRIORITY_W-1:0] priority_req,
   input  logic [GLYPH_W-1:0]    query_glyph,
   output mem_write_type         wr,
   output logic [ADDR_W-1:0]     rd_addr,
   output result_type            result
);

   logic [LEN_W-1:0]   qlen_ff, qlen_in;
   logic [LEN_W-1:0]   mpos_ff, mpos_in;
   logic [BONUS_W-1:0] bonus_ff, bonus_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               first_ff, first_in;

   logic               hit;
   logic               fold_equal;
   logic               exact;
   logic [BONUS_W:0]   increment;
   logic [SCORE_W:0]   score_sum;
   logic [SCORE_W-1:0] score_hit;

   assign hit        = (mpos_ff < qlen_ff);
   assign fold_equal = (fold_case(query_glyph) == fold_case(glyph));
   assign exact      = (query_glyph == glyph);
   assign increment  = (BONUS_W+1)'(bonus_ff) + (BONUS_W+1)'(first_ff) + (BONUS_W+1)'(exact);
   assign score_sum  = (SCORE_W+1)'(score_ff) + (SCORE_W+1)'(increment);
   assign score_hit  = (score_sum > (SCORE_W+1)'(SCORE_MAX)) ? SCORE_MAX
                                                             : score_sum[SCORE_W-1:0];

   always_comb begin
      logic               emit;
      logic               all_matched;
      logic [SCORE_W-1:0] base;
      logic [SCORE_W:0]   total;

      qlen_in  = qlen_ff;
      mpos_in  = mpos_ff;
      bonus_in = bonus_ff;
      score_in = score_ff;
      first_in = first_ff;
      wr.en    = 1'b0;
      wr.addr  = qlen_ff[ADDR_W-1:0];
      wr.data  = glyph;
      emit        = 1'b0;
      all_matched = 1'b0;
      base        = '0;

      if (accept) begin
         unique case (operation)
            OP_CLEAR: begin
               qlen_in = '0;
            end
            OP_APPEND: begin
               if (qlen_ff < LEN_W'(QUERY_DEPTH)) begin
                  wr.en   = 1'b1;
                  qlen_in = qlen_ff + LEN_W'(1);
               end
            end
            OP_DELETE: begin
               if (qlen_ff != '0) begin
                  qlen_in = qlen_ff - LEN_W'(1);
               end
            end
            OP_TEXT: begin
               if (hit && fold_equal) begin
                  mpos_in  = mpos_ff + LEN_W'(1);
                  bonus_in = bonus_ff + BONUS_W'(1);
                  score_in = score_hit;
               end else if (hit) begin
                  bonus_in = BONUS_W'(1);
               end
               first_in = 1'b0;
               if (last_glyph) begin
                  emit        = 1'b1;
                  all_matched = (mpos_in == qlen_ff);
                  base        = all_matched ? score_in : '0;
               end
            end
            OP_EMPTY: begin
               emit        = 1'b1;
               all_matched = (qlen_ff == '0);
               base        = all_matched ? BASE_SCORE : '0;
            end
            default: begin
            end
         endcase

         // Query edits and finished candidates start the next candidate afresh.
         if (operation == OP_CLEAR || operation == OP_APPEND || operation == OP_DELETE ||
             operation == OP_EMPTY || (operation == OP_TEXT && last_glyph)) begin
            mpos_in  = '0;
            bonus_in = BONUS_W'(1);
            score_in = BASE_SCORE;
            first_in = 1'b1;
         end
      end

      total          = (SCORE_W+1)'(base) + (SCORE_W+1)'(priority_req);
      result.valid   = emit;
      result.matched = all_matched;
      result.score   = (total > (SCORE_W+1)'(SCORE_MAX)) ? SCORE_MAX : total[SCORE_W-1:0];
   end

   // The memory is always addressed at the next match position, so its data is ready
   // when the next text glyph arrives.
   assign rd_addr = mpos_in[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff  <= '0;
         mpos_ff  <= '0;
         bonus_ff <= BONUS_W'(1);
         score_ff <= BASE_SCORE;
         first_ff <= 1'b1;
      end else begin
         qlen_ff  <= qlen_in;
         mpos_ff  <= mpos_in;
         bonus_ff <= bonus_in;
         score_ff <= score_in;
         first_ff <= first_in;
      end
   end

endmodule

// ===== design/fuzzy_subsequence_scorer_unit.sv =====
// Top level of the fuzzy subsequence scorer: query memory, match engine and result register.
//
//   Channel  Direction  Handshake            Payload
//   req_     in         req_valid/req_stall  operation, glyph, last_glyph, priority_req
//   rsp_     out        rsp_valid/rsp_stall  score, matched
//
// A new transaction is accepted each cycle unless requests stall. The match engine updates
// its running state per transaction and reads the query memory ahead of the next glyph,
// at the next match position, so the memory's read latency stays hidden.
// A result sits in the output register from the cycle after the transaction that causes it.
// Reset clears the query length and candidate state; no clearing pass is needed.
// Requests stall only while a result waits in the output register and the result side stalls.
module fuzzy_subsequence_scorer_unit
   import fss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [GLYPH_W-1:0]    req_glyph,
   input  logic                  req_last_glyph,
   input  logic [PRIORITY_W-1:0] req_priority_req,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SCORE_W-1:0]    rsp_score,
   output logic                  rsp_matched
);

   logic               accept;
   mem_write_type      wr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [GLYPH_W-1:0] query_glyph;
   result_type         result;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0] rsp_score_ff;
   logic               rsp_matched_ff;

   // The output register frees up in the same cycle it is drained, so a new transaction
   // can enter while the previous result is being taken.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   fss_query_mem u_query_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (query_glyph)
   );

   fss_match_engine u_match_engine (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_operation),
      .glyph        (req_glyph),
      .last_glyph   (req_last_glyph),
      .priority_req (req_priority_req),
      .query_glyph  (query_glyph),
      .wr           (wr),
      .rd_addr      (rd_addr),
      .result       (result)
   );

   always_comb begin
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The payload loads only with a new result, which holds it steady under a stall.
   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_score_ff   <= result.score;
         rsp_matched_ff <= result.matched;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_score   = rsp_score_ff;
   assign rsp_matched = rsp_matched_ff;

endmodule

// ===== design/fss_checker.sv =====
// Port-level checker of the fuzzy subsequence scorer and its bind to the top level.
module fss_checker
   import fss_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic [OP_W-1:0]       req_operation,
   input logic                  req_last_glyph,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [SCORE_W-1:0]    rsp_score,
   input logic                  rsp_matched
);

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_score) && $stable(rsp_matched))
      else $error("stalled result changed or vanished");

   // Requests stall only behind a pending, stalled result.
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a waiting result");

   // A transaction that ends a candidate produces a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      ((req_operation == OP_TEXT && req_last_glyph) || req_operation == OP_EMPTY)
      |=> rsp_valid)
      else $error("candidate ended without a result");

   // A full match carries at least the base score.
   a_matched_score: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matched |-> rsp_score >= BASE_SCORE)
      else $error("matched result below base score");

endmodule

bind fuzzy_subsequence_scorer_unit fss_checker u_fss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_operation  (req_operation),
   .req_last_glyph (req_last_glyph),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_score      (rsp_score),
   .rsp_matched    (rsp_matched)
);
